FILE: rtl/core/pftf_pkg.sv
// ----------------------------------------------------------------------------
// pftf_pkg
// Shared types and constants for the buffer-pool frame table with FIFO
// (rotating pointer) replacement.
// ----------------------------------------------------------------------------
package pftf_pkg;

    localparam int SLOTS  = 16;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int PAGE_W = 32;
    localparam int MODE_W = 2;
    localparam int SLOT_W = 4;

    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EVICT  = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_VREAD = 4'b0100,
        ST_VDATA = 4'b1000
    } state_t;

    // Access command from the controller to the frame store.
    typedef struct packed {
        logic              rd_en;
        logic [IDX_W-1:0]  rd_addr;
        logic              wr_en;     // write page and set present bit
        logic              clr_en;    // clear present bit
        logic [IDX_W-1:0]  wr_addr;
        logic [PAGE_W-1:0] wr_page;
    } frame_cmd_t;

    function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nxt;
        if (idx == LAST_IDX)
        begin
            nxt = '0;
        end
        else
        begin
            nxt = idx + 1'b1;
        end
        return nxt;
    endfunction

endpackage

FILE: rtl/core/pftf_if.sv
// ----------------------------------------------------------------------------
// pftf_in_if / pftf_out_if
// Valid/ready channels carrying request and result transactions.
// ----------------------------------------------------------------------------
interface pftf_in_if
    import pftf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [PAGE_W-1:0] page_number;

    modport source (output valid, output mode, output page_number, input ready);
    modport sink   (input valid, input mode, input page_number, output ready);
endinterface

interface pftf_out_if
    import pftf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [PAGE_W-1:0] victim_page;
    logic              victim_valid;

    modport source (output valid, output found, output slot, output victim_page,
                    output victim_valid, input ready);
    modport sink   (input valid, input found, input slot, input victim_page,
                    input victim_valid, output ready);
endinterface

FILE: rtl/core/pftf_frames.sv
// ----------------------------------------------------------------------------
// pftf_frames
// Frame store: page-number memory with registered read data, and the
// per-slot present bits in flops cleared by reset.
// ----------------------------------------------------------------------------
module pftf_frames
    import pftf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  frame_cmd_t        cmd,
    output logic [PAGE_W-1:0] rd_data,
    output logic [SLOTS-1:0]  present
);

    logic [PAGE_W-1:0] page_mem [SLOTS];
    logic [PAGE_W-1:0] rd_data_reg;
    logic [SLOTS-1:0]  present_reg;
    logic [SLOTS-1:0]  present_next;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            page_mem[cmd.wr_addr] <= cmd.wr_page;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= page_mem[cmd.rd_addr];
        end
    end

    always_comb
    begin
        present_next = present_reg;
        if (cmd.wr_en)
        begin
            present_next[cmd.wr_addr] = 1'b1;
        end
        else if (cmd.clr_en)
        begin
            present_next[cmd.wr_addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
        end
        else
        begin
            present_reg <= present_next;
        end
    end

    assign rd_data = rd_data_reg;
    assign present = present_reg;

endmodule

FILE: rtl/core/pftf_ctrl.sv
// ----------------------------------------------------------------------------
// pftf_ctrl
// Scan sequencer: except in mode three, walks the slots from the rotating
// pointer with one read in flight and acts on the first qualifying slot; then
// reads the victim slot and loads the result register.
// ----------------------------------------------------------------------------
module pftf_ctrl
    import pftf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    pftf_in_if.sink           in_ch,
    pftf_out_if.source        out_ch,
    output frame_cmd_t        cmd,
    input  logic [PAGE_W-1:0] rd_data,
    input  logic [SLOTS-1:0]  present
);

    state_t            state_reg, state_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [IDX_W-1:0]  rotor_reg, rotor_next;
    logic [IDX_W-1:0]  iss_ptr_reg, iss_ptr_next;
    logic [CNT_W-1:0]  iss_cnt_reg, iss_cnt_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]  cmp_ptr_reg, cmp_ptr_next;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  where_reg, where_next;

    logic              out_valid_reg, out_valid_next;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [PAGE_W-1:0] vpage_reg, vpage_next;
    logic              vvalid_reg, vvalid_next;

    logic cmp_present;
    logic qualify;
    logic hit_now;
    logic scan_done;
    logic in_fire;
    logic out_free;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;

    assign cmp_present = present[cmp_ptr_reg];

    always_comb
    begin
        case (mode_reg) inside
            MODE_ALLOC:              qualify = !cmp_present;
            MODE_LOOKUP, MODE_EVICT: qualify = cmp_present && (rd_data == page_reg);
            default:                 qualify = 1'b0;
        endcase
    end

    assign hit_now   = (state_reg == ST_SCAN) && cmp_vld_reg && qualify;
    assign scan_done = (iss_cnt_reg == CNT_W'(SLOTS));

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        page_next      = page_reg;
        rotor_next     = rotor_reg;
        iss_ptr_next   = iss_ptr_reg;
        iss_cnt_next   = iss_cnt_reg;
        cmp_vld_next   = 1'b0;
        cmp_ptr_next   = cmp_ptr_reg;
        hit_next       = hit_reg;
        where_next     = where_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        found_next     = found_reg;
        slot_next      = slot_reg;
        vpage_next     = vpage_reg;
        vvalid_next    = vvalid_reg;
        cmd            = '0;
        cmd.wr_addr    = cmp_ptr_reg;
        cmd.wr_page    = page_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    mode_next    = in_ch.mode;
                    page_next    = in_ch.page_number;
                    iss_ptr_next = rotor_reg;
                    iss_cnt_next = '0;
                    hit_next     = 1'b0;
                    where_next   = '0;
                    if (in_ch.mode == MODE_ALLOC || in_ch.mode == MODE_LOOKUP ||
                        in_ch.mode == MODE_EVICT)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_VREAD;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit_now)
                begin
                    hit_next   = 1'b1;
                    where_next = cmp_ptr_reg;
                    state_next = ST_VREAD;
                    if (mode_reg == MODE_ALLOC)
                    begin
                        cmd.wr_en  = 1'b1;
                        rotor_next = wrap_next(cmp_ptr_reg);
                    end
                    else if (mode_reg == MODE_EVICT)
                    begin
                        cmd.clr_en = 1'b1;
                        rotor_next = cmp_ptr_reg;
                    end
                end
                else if (scan_done)
                begin
                    // Full turn without a match: the pointer ends where it began.
                    state_next = ST_VREAD;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_addr  = iss_ptr_reg;
                    cmp_vld_next = 1'b1;
                    cmp_ptr_next = iss_ptr_reg;
                    iss_ptr_next = wrap_next(iss_ptr_reg);
                    iss_cnt_next = iss_cnt_reg + 1'b1;
                end
            end
            ST_VREAD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = rotor_reg;
                state_next  = ST_VDATA;
            end
            ST_VDATA:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = hit_reg;
                    slot_next      = hit_reg ? SLOT_W'(where_reg) : '0;
                    vvalid_next    = present[rotor_reg];
                    vpage_next     = present[rotor_reg] ? rd_data : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rotor_reg     <= '0;
            iss_cnt_reg   <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rotor_reg     <= rotor_next;
            iss_cnt_reg   <= iss_cnt_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        page_reg    <= page_next;
        iss_ptr_reg <= iss_ptr_next;
        cmp_ptr_reg <= cmp_ptr_next;
        hit_reg     <= hit_next;
        where_reg   <= where_next;
        found_reg   <= found_next;
        slot_reg    <= slot_next;
        vpage_reg   <= vpage_next;
        vvalid_reg  <= vvalid_next;
    end

    assign in_ch.ready         = (state_reg == ST_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.found        = found_reg;
    assign out_ch.slot         = slot_reg;
    assign out_ch.victim_page  = vpage_reg;
    assign out_ch.victim_valid = vvalid_reg;

    // A compare is pending in the scan exactly when at least one read was issued.
    a_cmp_tracks_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cmp_vld_reg == (iss_cnt_reg != '0)))
        else $error("compare stage out of step with issued reads");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        iss_cnt_reg <= CNT_W'(SLOTS))
        else $error("scan visited more slots than exist");

    a_alloc_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (hit_now && mode_reg == MODE_ALLOC) |=> present[$past(cmp_ptr_reg)])
        else $error("claimed slot not marked present");

    a_evict_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (hit_now && mode_reg == MODE_EVICT) |=> !present[$past(cmp_ptr_reg)])
        else $error("evicted slot still present");

endmodule

FILE: rtl/core/page_frame_table_fifo_top.sv
// ----------------------------------------------------------------------------
// page_frame_table_fifo_top
// Buffer-pool frame table with a rotating replacement pointer: allocate,
// look up and evict pages, reporting the slot at the pointer as victim.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                    Handshake
//  in_ch    in   mode, page_number                          valid/ready
//  out_ch   out  found, slot, victim_page, victim_valid     valid/ready
//
// An accepted request passes through the scan, the victim read and the victim
// data step before the result is loaded; the scan stops at the first match or
// after a full turn of the slots. Mode three skips the scan. The scan issues
// one page memory read per cycle, with the compare in the cycle after it.
// Reset clears all present bits and the pointer; page memory is not cleared.
// A new request is taken while a result waits; a stalled output holds the
// sequencer in its final step until the result register frees up.
// ----------------------------------------------------------------------------
module page_frame_table_fifo_top
    import pftf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pftf_in_if.sink    in_ch,
    pftf_out_if.source out_ch
);

    frame_cmd_t        cmd;
    logic [PAGE_W-1:0] rd_data;
    logic [SLOTS-1:0]  present;

    pftf_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cmd     (cmd),
        .rd_data (rd_data),
        .present (present)
    );

    pftf_frames u_frames (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rd_data (rd_data),
        .present (present)
    );

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the frame table with a rotating replacement pointer. A
// scoreboard class keeps its own copy of the present bits, page numbers and
// pointer, predicts the result of every accepted request, and compares each
// accepted result field by field. A directed run covers the edge cases, then
// random traffic runs in four phases that vary request idling and result stalling.
// ----------------------------------------------------------------------------
module tb
    import pftf_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
    localparam int RANDOM_PER_PHASE = 300;
    localparam int NUM_PHASES       = 4;
    localparam int POOL_SIZE        = 24;
    localparam int CYCLE_LIMIT      = 600000;
    localparam int MAX_PRINTS       = 60;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [PAGE_W-1:0] victim_page;
        logic              victim_valid;
    } frame_result_t;

    class frame_table_sb;
        bit                present[SLOTS];
        logic [PAGE_W-1:0] page_of[SLOTS];
        int                rotor;
        frame_result_t     due_results[$];
        int                errors;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                present[i] = 1'b0;
                page_of[i] = '0;
            end
            rotor  = 0;
            errors = 0;
        endfunction

        // Applies one accepted request to the table copy and queues its result.
        function void apply_request(logic [MODE_W-1:0] mode, logic [PAGE_W-1:0] pg);
            frame_result_t res;
            int            p;
            res = '0;
            case (mode)
                MODE_ALLOC:
                begin
                    for (int n = 0; n < SLOTS; n++)
                    begin
                        p     = rotor;
                        rotor = (rotor + 1) % SLOTS;
                        if (!present[p])
                        begin
                            present[p] = 1'b1;
                            page_of[p] = pg;
                            res.found  = 1'b1;
                            res.slot   = SLOT_W'(p);
                            break;
                        end
                    end
                end
                MODE_LOOKUP:
                begin
                    p = rotor;
                    for (int n = 0; n < SLOTS; n++)
                    begin
                        if (present[p] && page_of[p] == pg)
                        begin
                            res.found = 1'b1;
                            res.slot  = SLOT_W'(p);
                            break;
                        end
                        p = (p + 1) % SLOTS;
                    end
                end
                MODE_EVICT:
                begin
                    // A miss walks the pointer a full turn back to its start.
                    for (int n = 0; n < SLOTS; n++)
                    begin
                        if (present[rotor] && page_of[rotor] == pg)
                        begin
                            present[rotor] = 1'b0;
                            res.found      = 1'b1;
                            res.slot       = SLOT_W'(rotor);
                            break;
                        end
                        rotor = (rotor + 1) % SLOTS;
                    end
                end
                default:
                begin
                end
            endcase
            if (present[rotor])
            begin
                res.victim_page  = page_of[rotor];
                res.victim_valid = 1'b1;
            end
            due_results.push_back(res);
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS)
            begin
                $display("%0t: %s", $realtime, msg);
            end
            errors++;
        endtask

        task compare_result(frame_result_t got);
            frame_result_t want;
            if (due_results.size() == 0)
            begin
                report($sformatf("result with nothing outstanding: %p", got));
                return;
            end
            want = due_results.pop_front();
            if (got.found !== want.found)
            begin
                report($sformatf("found: got %b want %b", got.found, want.found));
            end
            if (got.slot !== want.slot)
            begin
                report($sformatf("slot: got %0d want %0d", got.slot, want.slot));
            end
            if (got.victim_page !== want.victim_page)
            begin
                report($sformatf("victim_page: got %h want %h",
                                 got.victim_page, want.victim_page));
            end
            if (got.victim_valid !== want.victim_valid)
            begin
                report($sformatf("victim_valid: got %b want %b",
                                 got.victim_valid, want.victim_valid));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    pftf_in_if  req_if();
    pftf_out_if rsp_if();

    page_frame_table_fifo_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (req_if),
        .out_ch (rsp_if)
    );

    frame_table_sb     book;
    logic [PAGE_W-1:0] page_pool[POOL_SIZE];
    int                idle_pct;
    int                stall_pct;
    int                cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Result side: check every accepted transaction, then pick the next ready.
    initial
    begin
        frame_result_t got;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            begin
                got.found        = rsp_if.found;
                got.slot         = rsp_if.slot;
                got.victim_page  = rsp_if.victim_page;
                got.victim_valid = rsp_if.victim_valid;
                book.compare_result(got);
            end
            rsp_if.ready <= (rst_n === 1'b1) && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task send_request(logic [MODE_W-1:0] mode, logic [PAGE_W-1:0] pg);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.mode        <= mode;
        req_if.page_number <= pg;
        do
        begin
            @(posedge clk);
        end
        while (req_if.ready !== 1'b1);
        book.apply_request(mode, pg);
    endtask

    function logic [PAGE_W-1:0] pick_page();
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom();
        end
        return page_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    task run_random(int count);
        logic [MODE_W-1:0] mode;
        int                alloc_pct;
        int                r;
        alloc_pct = 60;
        for (int i = 0; i < count; i++)
        begin
            // Swing between filling and draining so the table sees empty and full.
            if (i % 40 == 0)
            begin
                alloc_pct = (alloc_pct == 60) ? 20 : 60;
            end
            r = $urandom_range(0, 99);
            if (r < alloc_pct)
            begin
                mode = MODE_ALLOC;
            end
            else if (r < 95)
            begin
                mode = ($urandom_range(0, 1) == 0) ? MODE_LOOKUP : MODE_EVICT;
            end
            else
            begin
                mode = MODE_NOP;
            end
            send_request(mode, pick_page());
        end
    endtask

    initial
    begin
        book      = new();
        idle_pct  = 0;
        stall_pct = 0;
        page_pool[0] = '0;
        page_pool[1] = '1;
        page_pool[2] = 32'h5555_5555;
        page_pool[3] = 32'hAAAA_AAAA;
        for (int i = 4; i < POOL_SIZE; i++)
        begin
            page_pool[i] = $urandom();
        end

        rst_n              <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.mode        <= MODE_ALLOC;
        req_if.page_number <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme pages, duplicates, misses, the unused mode and a
        // full table.
        send_request(MODE_ALLOC, 32'h0000_0000);
        send_request(MODE_ALLOC, 32'hFFFF_FFFF);
        send_request(MODE_ALLOC, 32'hFFFF_FFFF);
        send_request(MODE_LOOKUP, 32'hFFFF_FFFF);
        send_request(MODE_LOOKUP, 32'h0000_0000);
        send_request(MODE_LOOKUP, 32'h1234_5678);
        send_request(MODE_EVICT, 32'hFFFF_FFFF);
        send_request(MODE_EVICT, 32'h1234_5678);
        send_request(MODE_NOP, 32'hAAAA_AAAA);
        for (int i = 0; i < SLOTS - 2; i++)
        begin
            send_request(MODE_ALLOC, (i % 2 == 0) ? 32'h5555_5555 + i : 32'hAAAA_AAAA - i);
        end
        send_request(MODE_ALLOC, 32'h8000_0001);
        send_request(MODE_EVICT, 32'h0000_0000);
        send_request(MODE_LOOKUP, 32'h0000_0000);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 47;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 47;
                end
                default:
                begin
                    idle_pct  = 15;
                    stall_pct = 15;
                end
            endcase
            run_random(RANDOM_PER_PHASE);
        end

        req_if.valid <= 1'b0;
        while (book.outstanding() > 0)
        begin
            @(posedge clk);
        end
        repeat (2 * (SLOTS + 3)) @(posedge clk);
        if (book.errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
